/* hw/rtl/sasa_pkg.sv */
// Package for the sample statistics accumulator: field widths, command and
// state types shared by the front, queue and back modules. No dependencies.
`default_nettype none
package sasa_pkg;

   localparam int SampleWidth = 24;
   localparam int CountWidth  = 16;
   localparam int SumWidth    = 40;
   localparam int SquareWidth = 62;
   localparam int DevWidth    = 23;
   localparam int WideWidth   = 80;
   localparam int DenWidth    = 32;
   localparam int RootWidth   = 64;
   localparam int IterWidth   = 7;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_REPORT = 2'd2
   } action_type;

   typedef struct packed {
      action_type              action;
      logic signed [SampleWidth-1:0] sample;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MULA,
      ST_MULB,
      ST_VDIV,
      ST_SQRT,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/sasa_front.sv */
// Front end of the sample statistics accumulator: accepts request words,
// drops unused action codes and sign-extends samples. Uses sasa_pkg.
`default_nettype none
module sasa_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_action,
   input  wire logic signed [sasa_pkg::SampleWidth-1:0] req_sample_value,
   input  wire logic                                queue_full,
   output sasa_pkg::push_type                       push
);

   localparam int ExtShift = sasa_pkg::SampleWidth - SAMPLE_BITS;

   logic signed [sasa_pkg::SampleWidth-1:0] shifted;
   logic                                    known;

   assign req_ready = !queue_full;
   assign shifted   = req_sample_value <<< ExtShift;

   always_comb begin
      case (req_action)
         sasa_pkg::ACT_ADD, sasa_pkg::ACT_CLEAR, sasa_pkg::ACT_REPORT: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   always_comb begin
      push.valid      = req_valid && !queue_full && known;
      push.cmd.action = sasa_pkg::action_type'(req_action);
      push.cmd.sample = shifted >>> ExtShift;
   end

endmodule
`default_nettype wire

/* hw/rtl/sasa_queue.sv */
// Two-entry command queue between the front and back of the accumulator.
// Uses sasa_pkg for the command type.
`default_nettype none
module sasa_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sasa_pkg::push_type push,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output sasa_pkg::cmd_type       head_cmd
);

   sasa_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/sasa_back.sv */
// Back end of the accumulator: running state, serial multiplier, divider and
// square root for reports, and the result register. Uses sasa_pkg.
`default_nettype none
module sasa_back #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  head_valid,
   input  wire sasa_pkg::cmd_type                     head_cmd,
   output logic                                       pop,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [sasa_pkg::CountWidth-1:0]            rsp_sample_total_count,
   output logic signed [sasa_pkg::SampleWidth-1:0]    rsp_mean_value,
   output logic signed [sasa_pkg::SampleWidth-1:0]    rsp_minimum_value,
   output logic signed [sasa_pkg::SampleWidth-1:0]    rsp_maximum_value,
   output logic [sasa_pkg::DevWidth-1:0]              rsp_std_deviation,
   output logic signed [sasa_pkg::SumWidth-1:0]       rsp_total_sum,
   output logic                                       rsp_deviation_valid,
   output logic                                       rsp_count_saturated
);

   localparam int CW = sasa_pkg::CountWidth;
   localparam int SW = sasa_pkg::SampleWidth;
   localparam int UW = sasa_pkg::SumWidth;
   localparam int QW = sasa_pkg::SquareWidth;
   localparam int WW = sasa_pkg::WideWidth;
   localparam int DW = sasa_pkg::DenWidth;
   localparam int RW = sasa_pkg::RootWidth;
   localparam int IW = sasa_pkg::IterWidth;
   localparam logic [CW-1:0] CountLimit = CW'((32'd1 << COUNT_BITS) - 32'd1);
   localparam logic [IW-1:0] DivLast    = IW'(WW - 1);
   localparam logic [IW-1:0] MulLast    = IW'(UW - 1);
   localparam logic [IW-1:0] RootLast   = IW'(RW / 2 - 1);
   localparam logic [RW-1:0] RootTop    = RW'(1) << (RW - 2);
   localparam logic [RW-1:0] DevMax     = RW'((64'd1 << sasa_pkg::DevWidth) - 64'd1);

   sasa_pkg::state_type state_ff, state_in;

   // running state
   logic [CW-1:0]        held_count_ff, held_count_in;
   logic signed [UW-1:0] sum_ff, sum_in;
   logic [QW-1:0]        square_ff, square_in;
   logic signed [SW-1:0] min_ff, min_in, max_ff, max_in;
   logic                 dropped_ff, dropped_in;

   // report datapath
   logic [WW-1:0] mcand_ff, mcand_in, prod_ff, prod_in, a_ff, a_in;
   logic [UW-1:0] mplier_ff, mplier_in;
   logic [WW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic signed [SW-1:0] mean_ff, mean_in;
   logic [RW-1:0] rootv_ff, rootv_in, root_ff, root_in, rbit_ff, rbit_in;
   logic [sasa_pkg::DevWidth-1:0] sd_ff, sd_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        rsp_count_ff;
   logic signed [SW-1:0] rsp_mean_ff, rsp_min_ff, rsp_max_ff;
   logic [sasa_pkg::DevWidth-1:0] rsp_sd_ff;
   logic signed [UW-1:0] rsp_sum_ff;
   logic                 rsp_devv_ff, rsp_sat_ff;

   logic                 load_rsp;
   logic                 out_free;
   logic [SW:0]          mag;
   logic [2*SW+1:0]      mag_sq;
   logic [UW-1:0]        sum_mag;
   logic [DW:0]          rem_sh;
   logic                 rem_ge;
   logic [WW-1:0]        div_q, mul_p;
   logic [RW-1:0]        trial;
   logic [RW-1:0]        root_next;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sasa_pkg::ST_IDLE: begin
            if (head_valid && head_cmd.action == sasa_pkg::ACT_REPORT) begin
               state_in = (held_count_ff == '0) ? sasa_pkg::ST_OUT : sasa_pkg::ST_MEAN;
            end
         end
         sasa_pkg::ST_MEAN: begin
            if (iter_ff == DivLast) begin
               state_in = (held_count_ff >= CW'(2)) ? sasa_pkg::ST_MULA : sasa_pkg::ST_OUT;
            end
         end
         sasa_pkg::ST_MULA: if (iter_ff == MulLast) state_in = sasa_pkg::ST_MULB;
         sasa_pkg::ST_MULB: if (iter_ff == MulLast) state_in = sasa_pkg::ST_VDIV;
         sasa_pkg::ST_VDIV: if (iter_ff == DivLast) state_in = sasa_pkg::ST_SQRT;
         sasa_pkg::ST_SQRT: if (iter_ff == RootLast) state_in = sasa_pkg::ST_OUT;
         sasa_pkg::ST_OUT:  if (out_free) state_in = sasa_pkg::ST_IDLE;
         default: state_in = sasa_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop      = (state_ff == sasa_pkg::ST_IDLE) && head_valid;
      load_rsp = (state_ff == sasa_pkg::ST_OUT) && out_free;
   end

   // shared arithmetic steps
   always_comb begin
      mag       = head_cmd.sample[SW-1] ? (SW+1)'(-$signed({head_cmd.sample[SW-1], head_cmd.sample}))
                                        : (SW+1)'(head_cmd.sample);
      mag_sq    = (2*SW+2)'(mag) * (2*SW+2)'(mag);
      sum_mag   = sum_ff[UW-1] ? UW'(-sum_ff) : UW'(sum_ff);
      rem_sh    = {rem_ff[DW-1:0], num_ff[WW-1]};
      rem_ge    = rem_sh >= {1'b0, den_ff};
      div_q     = {quo_ff[WW-2:0], rem_ge};
      mul_p     = prod_ff + (mplier_ff[0] ? mcand_ff : '0);
      trial     = root_ff + rbit_ff;
      root_next = (rootv_ff >= trial) ? ((root_ff >> 1) + rbit_ff) : (root_ff >> 1);
   end

   // datapath
   always_comb begin
      held_count_in = held_count_ff;
      sum_in        = sum_ff;
      square_in     = square_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      dropped_in    = dropped_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      prod_in       = prod_ff;
      a_in          = a_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      iter_in       = iter_ff + IW'(1);
      mean_in       = mean_ff;
      rootv_in      = rootv_ff;
      root_in       = root_ff;
      rbit_in       = rbit_ff;
      sd_in         = sd_ff;
      case (state_ff)
         sasa_pkg::ST_IDLE: begin
            iter_in = '0;
            if (pop) begin
               case (head_cmd.action)
                  sasa_pkg::ACT_ADD: begin
                     if (held_count_ff >= CountLimit) begin
                        dropped_in = 1'b1;
                     end else begin
                        if (held_count_ff == '0 || head_cmd.sample < min_ff) min_in = head_cmd.sample;
                        if (held_count_ff == '0 || head_cmd.sample > max_ff) max_in = head_cmd.sample;
                        held_count_in = held_count_ff + CW'(1);
                        sum_in        = sum_ff + UW'(head_cmd.sample);
                        square_in     = square_ff + QW'(mag_sq);
                     end
                  end
                  sasa_pkg::ACT_CLEAR: begin
                     held_count_in = '0;
                     sum_in        = '0;
                     square_in     = '0;
                     min_in        = '0;
                     max_in        = '0;
                     dropped_in    = 1'b0;
                  end
                  default: begin
                     mean_in = '0;
                     sd_in   = '0;
                     num_in  = WW'(sum_mag);
                     den_in  = DW'(held_count_ff);
                     rem_in  = '0;
                     quo_in  = '0;
                  end
               endcase
            end
         end
         sasa_pkg::ST_MEAN, sasa_pkg::ST_VDIV: begin
            num_in = num_ff << 1;
            quo_in = div_q;
            rem_in = rem_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            if (iter_ff == DivLast) begin
               iter_in = '0;
               if (state_ff == sasa_pkg::ST_MEAN) begin
                  mean_in   = sum_ff[UW-1] ? -SW'(div_q) : SW'(div_q);
                  mcand_in  = WW'(square_ff);
                  mplier_in = UW'(held_count_ff);
                  prod_in   = '0;
                  den_in    = DW'(held_count_ff) * DW'(held_count_ff - CW'(1));
               end else begin
                  rootv_in = div_q[RW-1:0];
                  root_in  = '0;
                  rbit_in  = RootTop;
               end
            end
         end
         sasa_pkg::ST_MULA, sasa_pkg::ST_MULB: begin
            prod_in   = mul_p;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (iter_ff == MulLast) begin
               iter_in = '0;
               if (state_ff == sasa_pkg::ST_MULA) begin
                  a_in      = mul_p;
                  mcand_in  = WW'(sum_mag);
                  mplier_in = sum_mag;
                  prod_in   = '0;
               end else begin
                  num_in = (a_ff >= mul_p) ? (a_ff - mul_p) : '0;
                  rem_in = '0;
                  quo_in = '0;
               end
            end
         end
         sasa_pkg::ST_SQRT: begin
            if (rootv_ff >= trial) rootv_in = rootv_ff - trial;
            root_in = root_next;
            rbit_in = rbit_ff >> 2;
            if (iter_ff == RootLast) begin
               sd_in = (root_next > DevMax) ? DevMax[sasa_pkg::DevWidth-1:0]
                                            : root_next[sasa_pkg::DevWidth-1:0];
            end
         end
         default: iter_in = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sasa_pkg::ST_IDLE;
         held_count_ff <= '0;
         sum_ff        <= '0;
         square_ff     <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         dropped_ff    <= 1'b0;
         iter_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         sum_ff        <= sum_in;
         square_ff     <= square_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         dropped_ff    <= dropped_in;
         iter_ff       <= iter_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      a_ff      <= a_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      mean_ff   <= mean_in;
      rootv_ff  <= rootv_in;
      root_ff   <= root_in;
      rbit_ff   <= rbit_in;
      sd_ff     <= sd_in;
      if (load_rsp) begin
         rsp_count_ff <= held_count_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_min_ff   <= min_ff;
         rsp_max_ff   <= max_ff;
         rsp_sd_ff    <= sd_ff;
         rsp_sum_ff   <= sum_ff;
         rsp_devv_ff  <= (held_count_ff >= CW'(2));
         rsp_sat_ff   <= dropped_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_sample_total_count = rsp_count_ff;
   assign rsp_mean_value         = rsp_mean_ff;
   assign rsp_minimum_value      = rsp_min_ff;
   assign rsp_maximum_value      = rsp_max_ff;
   assign rsp_std_deviation      = rsp_sd_ff;
   assign rsp_total_sum          = rsp_sum_ff;
   assign rsp_deviation_valid    = rsp_devv_ff;
   assign rsp_count_saturated    = rsp_sat_ff;

   a_devv_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_devv_ff |-> rsp_count_ff >= CW'(2))
      else $error("deviation flagged valid with fewer than two samples");

   a_state_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff != sasa_pkg::ST_IDLE |=> $stable(held_count_ff) && $stable(sum_ff))
      else $error("running state changed while a report was being computed");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_count_ff != '0 |-> rsp_min_ff <= rsp_max_ff)
      else $error("reported minimum exceeds maximum");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> held_count_ff == CountLimit)
      else $error("sample dropped while the count was not full");

endmodule
`default_nettype wire

/* hw/rtl/sample_statistics_accumulator_core.sv */
// Top level of the sample statistics accumulator: front end, command queue
// and back end. Depends on sasa_pkg, sasa_front, sasa_queue and sasa_back.
//
// Usage. Request words arrive on req_valid/req_ready with an action code
// and a signed Q12.12 sample. Action add folds the sample into the running
// count, sum, sum of squares, minimum and maximum; clear empties the set;
// report produces one result word on rsp_valid/rsp_ready. The unused action
// code is accepted and discarded. Add and clear produce no result word.
// The command queue holds up to two commands, so requests are still accepted
// while the back end computes or a result waits for the receiver.
// Timing. Adds and clears stream at one word per cycle while no report is
// being computed. A report on an empty set goes straight to the result
// register; with one sample the serial divider forms the mean first; with
// two or more the back end runs mean division, two shift-add
// multiplications, variance division and a bit-pair square root in that
// order. Later commands wait in the queue meanwhile.
// Reset (synchronous, active high) empties the set and the queue and drops
// any pending result. While the receiver stalls, the result word is held
// and the back end waits before writing the next one.
`default_nettype none
module sample_statistics_accumulator_core #(
   parameter int COUNT_BITS  = 16,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_action,
   input  wire logic signed [sasa_pkg::SampleWidth-1:0] req_sample_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [sasa_pkg::CountWidth-1:0]            rsp_sample_total_count,
   output logic signed [sasa_pkg::SampleWidth-1:0]    rsp_mean_value,
   output logic signed [sasa_pkg::SampleWidth-1:0]    rsp_minimum_value,
   output logic signed [sasa_pkg::SampleWidth-1:0]    rsp_maximum_value,
   output logic [sasa_pkg::DevWidth-1:0]              rsp_std_deviation,
   output logic signed [sasa_pkg::SumWidth-1:0]       rsp_total_sum,
   output logic                                       rsp_deviation_valid,
   output logic                                       rsp_count_saturated
);

   sasa_pkg::push_type push;
   sasa_pkg::cmd_type  head_cmd;
   logic               queue_full;
   logic               head_valid;
   logic               pop;

   // The front end classifies words and sign-extends the sample field.
   sasa_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_sample_value (req_sample_value),
      .queue_full       (queue_full),
      .push             (push)
   );

   // The queue decouples acceptance from the long report sequence.
   sasa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The back end holds the running state and computes reports.
   sasa_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head_valid             (head_valid),
      .head_cmd               (head_cmd),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_sample_total_count (rsp_sample_total_count),
      .rsp_mean_value         (rsp_mean_value),
      .rsp_minimum_value      (rsp_minimum_value),
      .rsp_maximum_value      (rsp_maximum_value),
      .rsp_std_deviation      (rsp_std_deviation),
      .rsp_total_sum          (rsp_total_sum),
      .rsp_deviation_valid    (rsp_deviation_valid),
      .rsp_count_saturated    (rsp_count_saturated)
   );

endmodule
`default_nettype wire

/* tb/sv/tb_sample_statistics_accumulator_core.sv */
// Testbench for sample_statistics_accumulator_core: drives request words, predicts every
// report word from its own copy of the running statistics and checks each result field.
// Depends on sasa_pkg and the RTL of the block.
`default_nettype none
module tb_sample_statistics_accumulator_core;
   timeunit 1ns;
   timeprecision 1ps;

   // The fourth action code is not in the package enum; the block must swallow it.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [15:0] COUNT_FULL = 16'hFFFF;
   localparam logic [22:0] DEV_CEILING = 23'h7FFFFF;
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_WORDS = 1850;

   // One report word as the block should present it.
   typedef struct {
      logic [15:0]        count;
      logic signed [23:0] mean;
      logic signed [23:0] minimum;
      logic signed [23:0] maximum;
      logic [22:0]        deviation;
      logic signed [39:0] total;
      logic               dev_valid;
      logic               saturated;
   } stats_word_type;

   // Keeps its own running statistics and the queue of report words still owed.
   class stats_scoreboard_type;
      bit [15:0]  held;
      longint     sum;
      bit [63:0]  square_sum;
      longint     lowest;
      longint     highest;
      bit         dropped;
      stats_word_type owed[$];
      int         errors;

      function void empty_set();
         held = 0;
         sum = 0;
         square_sum = 0;
         lowest = 0;
         highest = 0;
         dropped = 0;
      endfunction

      function bit [63:0] int_root(bit [63:0] v);
         bit [63:0] r;
         bit [63:0] b;
         r = 0;
         b = 64'h1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Folds an accepted request word into the state and queues any report it causes.
      function void note_request(logic [1:0] act, logic signed [23:0] sample);
         longint     s;
         bit [63:0]  mag;
         bit [63:0]  smag;
         bit [127:0] scaled;
         bit [127:0] squared;
         bit [63:0]  variance;
         bit [63:0]  root;
         stats_word_type w;
         s = sample;
         case (act)
            sasa_pkg::ACT_ADD: begin
               mag = (s < 0) ? -s : s;
               if (held == COUNT_FULL) begin
                  dropped = 1;
               end else begin
                  if (held == 0) begin
                     lowest = s;
                     highest = s;
                  end else begin
                     if (s < lowest) lowest = s;
                     if (s > highest) highest = s;
                  end
                  held++;
                  sum += s;
                  square_sum += mag * mag;
               end
            end
            sasa_pkg::ACT_CLEAR: empty_set();
            sasa_pkg::ACT_REPORT: begin
               w.count = held;
               w.mean = 0;
               w.minimum = 0;
               w.maximum = 0;
               w.total = 0;
               w.deviation = 0;
               w.dev_valid = 0;
               w.saturated = dropped;
               if (held > 0) begin
                  w.mean = sum / longint'(held);
                  w.minimum = lowest;
                  w.maximum = highest;
                  w.total = sum;
               end
               if (held >= 2) begin
                  smag = (sum < 0) ? -sum : sum;
                  scaled = 128'(square_sum) * 128'(held);
                  squared = 128'(smag) * 128'(smag);
                  variance = 0;
                  if (scaled >= squared)
                     variance = 64'((scaled - squared) /
                                    (128'(held) * 128'(held - 1)));
                  root = int_root(variance);
                  w.deviation = (root > DEV_CEILING) ? DEV_CEILING : root[22:0];
                  w.dev_valid = 1;
               end
               owed.push_back(w);
            end
            default: ;
         endcase
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch on %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(stats_word_type got);
         stats_word_type w;
         if (owed.size() == 0) begin
            report("unexpected result word", 1, 0);
         end else begin
            w = owed.pop_front();
            if (got.count !== w.count) report("sample_total_count", got.count, w.count);
            if (got.mean !== w.mean) report("mean_value", got.mean, w.mean);
            if (got.minimum !== w.minimum) report("minimum_value", got.minimum, w.minimum);
            if (got.maximum !== w.maximum) report("maximum_value", got.maximum, w.maximum);
            if (got.deviation !== w.deviation)
               report("std_deviation", got.deviation, w.deviation);
            if (got.total !== w.total) report("total_sum", got.total, w.total);
            if (got.dev_valid !== w.dev_valid)
               report("deviation_valid", got.dev_valid, w.dev_valid);
            if (got.saturated !== w.saturated)
               report("count_saturated", got.saturated, w.saturated);
         end
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_action = sasa_pkg::ACT_ADD;
   logic signed [23:0] req_sample_value = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [15:0]        rsp_sample_total_count;
   logic signed [23:0] rsp_mean_value;
   logic signed [23:0] rsp_minimum_value;
   logic signed [23:0] rsp_maximum_value;
   logic [22:0]        rsp_std_deviation;
   logic signed [39:0] rsp_total_sum;
   logic               rsp_deviation_valid;
   logic               rsp_count_saturated;

   stats_scoreboard_type sb = new();
   // When set, the sender or the receiver runs back to back without idling.
   bit sender_steady = 0;
   bit receiver_steady = 0;
   int quiet_cycles = 0;

   sample_statistics_accumulator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_sample_value(req_sample_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sample_total_count(rsp_sample_total_count),
      .rsp_mean_value(rsp_mean_value),
      .rsp_minimum_value(rsp_minimum_value),
      .rsp_maximum_value(rsp_maximum_value),
      .rsp_std_deviation(rsp_std_deviation),
      .rsp_total_sum(rsp_total_sum),
      .rsp_deviation_valid(rsp_deviation_valid),
      .rsp_count_saturated(rsp_count_saturated)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Presents one request word after an optional idle gap and holds it until accepted.
   // Valid is only lowered when a gap follows, so back-to-back words never see valid
   // dropped and raised in the same time step.
   task send_word(logic [1:0] act, logic signed [23:0] sample, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_sample_value <= sample;
      do @(posedge clock); while (!req_ready);
      sb.note_request(act, sample);
   endtask

   function int sender_gap();
      return sender_steady ? 0 : $urandom_range(0, 8);
   endfunction

   // Samples near the extremes and near zero are favoured, so that min, max, sign
   // handling and the saturating deviation all see plenty of traffic.
   function logic signed [23:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF - $urandom_range(0, 3);
         1: return 24'sh800000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Withdraws the request and waits until every owed report word has come back.
   task drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.owed.size() > 0) @(posedge clock);
   endtask

   // Receiver: draws a stall before each word, checks each accepted word.
   initial begin
      int gap;
      stats_word_type got;
      @(negedge reset);
      forever begin
         gap = receiver_steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         got.count = rsp_sample_total_count;
         got.mean = rsp_mean_value;
         got.minimum = rsp_minimum_value;
         got.maximum = rsp_maximum_value;
         got.deviation = rsp_std_deviation;
         got.total = rsp_total_sum;
         got.dev_valid = rsp_deviation_valid;
         got.saturated = rsp_count_saturated;
         sb.check_result(got);
      end
   end

   // Watchdog: reports and the random idle gaps of both sides are bounded, so a long
   // run with no word moving means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("sample_statistics_accumulator_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      int          r;
      logic [1:0]  act;
      sb.empty_set();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed words: empty set, single sample, extremes, clear and the unused code.
      send_word(sasa_pkg::ACT_REPORT, 0, sender_gap());
      send_word(sasa_pkg::ACT_ADD, 24'sh7FFFFF, sender_gap());
      send_word(sasa_pkg::ACT_REPORT, 0, sender_gap());
      send_word(sasa_pkg::ACT_ADD, 24'sh800000, sender_gap());
      send_word(sasa_pkg::ACT_REPORT, 0, sender_gap());
      send_word(ACT_UNUSED, 24'sh123456, sender_gap());
      send_word(sasa_pkg::ACT_ADD, 0, sender_gap());
      send_word(sasa_pkg::ACT_ADD, -1, sender_gap());
      send_word(sasa_pkg::ACT_ADD, 1, sender_gap());
      send_word(sasa_pkg::ACT_REPORT, 0, sender_gap());
      send_word(sasa_pkg::ACT_CLEAR, 24'sh7FFFFF, sender_gap());
      send_word(sasa_pkg::ACT_REPORT, 0, sender_gap());
      send_word(sasa_pkg::ACT_ADD, -4096, sender_gap());
      send_word(sasa_pkg::ACT_ADD, -4096, sender_gap());
      send_word(sasa_pkg::ACT_REPORT, 0, sender_gap());
      send_word(sasa_pkg::ACT_CLEAR, 0, sender_gap());

      // The sender holds off here until every owed report word has come back.
      drain();

      // Random traffic: mostly adds, with reports, clears and the odd unused code.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 99) == 0) sender_steady = !sender_steady;
         if ($urandom_range(0, 99) == 0) receiver_steady = !receiver_steady;
         r = $urandom_range(0, 99);
         if (r < 78) act = sasa_pkg::ACT_ADD;
         else if (r < 91) act = sasa_pkg::ACT_REPORT;
         else if (r < 97) act = sasa_pkg::ACT_CLEAR;
         else act = ACT_UNUSED;
         send_word(act, pick_sample(), sender_gap());
      end

      drain();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("sample_statistics_accumulator_core verification clean");
      end else begin
         $display("sample_statistics_accumulator_core verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
